[design/stpf_pkg.sv]
// stpf_pkg: shared widths, constants and the queue item type for the
// spectrum two-peak finder. No dependencies.
package stpf_pkg;

  localparam int REAL_W            = 16;
  localparam int LEVEL_W           = 17;
  localparam int INDEX_W           = 9;
  localparam int GUARD_W           = 6;
  localparam int RAD_W             = 2 * LEVEL_W;
  localparam int REM_W             = LEVEL_W + 3;
  localparam int ROOT_STAGES       = LEVEL_W;
  localparam int QUEUE_DEPTH       = 4;
  localparam int BIN_COUNT_DEFAULT = 512;

  localparam logic [GUARD_W-1:0] GUARD_RESET = GUARD_W'(10);

  typedef struct packed {
    logic               last;
    logic [LEVEL_W-1:0] level;
  } bin_item_t;

endpackage

[design/stpf_front.sv]
// stpf_front: accepts bins, forms the power word and takes its integer
// square root in a one-bit-per-stage pipeline. Depends on stpf_pkg.
module stpf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [stpf_pkg::REAL_W-1:0]  real_part,
  input  logic signed [stpf_pkg::REAL_W-1:0]  imag_part,
  input  logic                                last_bin,
  output logic                                push_valid,
  input  logic                                push_ready,
  output stpf_pkg::bin_item_t                 push_item
);
  import stpf_pkg::*;

  logic                        adv;
  logic                        accept;
  logic                        first_bin;
  logic signed [2*REAL_W-1:0]  re_sq;
  logic signed [2*REAL_W-1:0]  im_sq;
  logic                        p1_vld;
  logic                        p1_last;
  logic                        p1_first;
  logic [2*REAL_W-2:0]         p1_re;
  logic [2*REAL_W-2:0]         p1_im;
  logic [2*REAL_W-1:0]         sum;
  logic                        p2_vld;
  logic                        p2_last;
  logic [RAD_W-1:0]            p2_rad;

  logic                        vld  [ROOT_STAGES+1];
  logic                        lst  [ROOT_STAGES+1];
  logic [RAD_W-1:0]            rad  [ROOT_STAGES+1];
  logic [LEVEL_W-1:0]          root [ROOT_STAGES+1];
  logic [REM_W-1:0]            rem  [ROOT_STAGES+1];

  assign adv      = !vld[ROOT_STAGES] || push_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  assign re_sq = real_part * real_part;
  assign im_sq = imag_part * imag_part;
  assign sum   = {1'b0, p1_re} + {1'b0, p1_im};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_bin <= 1'b1;
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
    end else if (adv) begin
      if (accept) begin
        first_bin <= last_bin;
      end
      p1_vld <= accept;
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_re    <= re_sq[2*REAL_W-2:0];
      p1_im    <= im_sq[2*REAL_W-2:0];
      p1_last  <= last_bin;
      p1_first <= first_bin;
      p2_last  <= p1_last;
      p2_rad   <= p1_first ? RAD_W'(sum) : (RAD_W'(sum) << 2);
    end
  end

  assign vld[0]  = p2_vld;
  assign lst[0]  = p2_last;
  assign rad[0]  = p2_rad;
  assign root[0] = '0;
  assign rem[0]  = '0;

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {rem[k][REM_W-3:0], rad[k][RAD_W-1 -: 2]};
    assign trial  = REM_W'({root[k], 2'b01});
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lst[k+1]  <= lst[k];
        rad[k+1]  <= rad[k] << 2;
        root[k+1] <= {root[k][LEVEL_W-2:0], fits};
        rem[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
      end
    end
  end

  assign push_valid      = vld[ROOT_STAGES];
  assign push_item.last  = lst[ROOT_STAGES];
  assign push_item.level = root[ROOT_STAGES];

endmodule

[design/stpf_queue.sv]
// stpf_queue: short FIFO of finished magnitudes between the front and
// the back. Depends on stpf_pkg.
module stpf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  stpf_pkg::bin_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output stpf_pkg::bin_item_t pop_item
);
  import stpf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bin_item_t          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[design/stpf_back.sv]
// stpf_back: stores magnitudes, tracks the first peak while filling, runs
// the second-peak pass over the store and holds the result. Depends on stpf_pkg.
module stpf_back #(
  parameter int BIN_COUNT = stpf_pkg::BIN_COUNT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  stpf_pkg::bin_item_t               pop_item,
  input  logic [stpf_pkg::GUARD_W-1:0]      guard_bins,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stpf_pkg::INDEX_W-1:0]      first_index,
  output logic [stpf_pkg::LEVEL_W-1:0]      first_level,
  output logic [stpf_pkg::INDEX_W-1:0]      second_index,
  output logic [stpf_pkg::LEVEL_W-1:0]      second_level
);
  import stpf_pkg::*;

  localparam int PW = $clog2(BIN_COUNT + 1);
  localparam int IW = $clog2(BIN_COUNT);
  localparam int SW = ((PW > GUARD_W) ? PW : GUARD_W) + 1;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [LEVEL_W-1:0] mem [BIN_COUNT];
  logic [LEVEL_W-1:0] rd_data;

  logic [1:0]         state;
  logic [PW-1:0]      wp;
  logic [PW-1:0]      count;
  logic [PW-1:0]      scan_ptr;
  logic [PW-1:0]      rd_idx;
  logic               rd_vld;
  logic [LEVEL_W-1:0] run_level;
  logic [PW-1:0]      run_idx;
  logic [LEVEL_W-1:0] peak_level;
  logic [PW-1:0]      peak_idx;
  logic [LEVEL_W-1:0] sec_level;
  logic [PW-1:0]      sec_idx;

  logic               pop;
  logic               store_en;
  logic               take;
  logic [LEVEL_W-1:0] new_level;
  logic [PW-1:0]      new_idx;
  logic               scan_issue;
  logic               load;
  logic [SW-1:0]      idx_w;
  logic [SW-1:0]      peak_w;
  logic [SW-1:0]      guard_w;
  logic               skip;

  assign pop_ready  = state == ST_FILL;
  assign pop        = pop_valid && pop_ready;
  assign store_en   = pop && (wp < PW'(BIN_COUNT));
  assign take       = store_en && (wp != '0) && (pop_item.level > run_level);
  assign new_level  = take ? pop_item.level : run_level;
  assign new_idx    = take ? wp : run_idx;
  assign scan_issue = (state == ST_SCAN) && (scan_ptr < count);
  assign load       = (state == ST_DONE) && (!out_valid || out_ready);

  assign idx_w   = SW'(rd_idx);
  assign peak_w  = SW'(peak_idx);
  assign guard_w = SW'(guard_bins);
  assign skip    = (idx_w + guard_w >= peak_w) && (idx_w < peak_w + guard_w);

  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[wp[IW-1:0]] <= pop_item.level;
    end
    if (scan_issue) begin
      rd_data <= mem[scan_ptr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      wp         <= '0;
      count      <= '0;
      scan_ptr   <= '0;
      rd_idx     <= '0;
      rd_vld     <= 1'b0;
      run_level  <= '0;
      run_idx    <= '0;
      peak_level <= '0;
      peak_idx   <= '0;
      sec_level  <= '0;
      sec_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      rd_idx <= scan_ptr;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_FILL: begin
          if (pop) begin
            if (pop_item.last) begin
              peak_level <= new_level;
              peak_idx   <= new_idx;
              run_level  <= '0;
              run_idx    <= '0;
              wp         <= '0;
              count      <= store_en ? wp + 1'b1 : wp;
              scan_ptr   <= PW'(1);
              sec_level  <= '0;
              sec_idx    <= '0;
              state      <= ST_SCAN;
            end else begin
              if (store_en) begin
                wp <= wp + 1'b1;
              end
              run_level <= new_level;
              run_idx   <= new_idx;
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_ptr <= scan_ptr + 1'b1;
          end
          if (rd_vld && !skip && (rd_data > sec_level)) begin
            sec_level <= rd_data;
            sec_idx   <= rd_idx;
          end
          if (!scan_issue && !rd_vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state <= ST_FILL;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_index  <= INDEX_W'(peak_idx);
      first_level  <= peak_level;
      second_index <= INDEX_W'(sec_idx);
      second_level <= sec_level;
    end
  end

endmodule

[design/spectrum_two_peak_finder.sv]
// Spectrum two-peak finder. Bins stream in at one per cycle while in_ready is
// high; each passes a two-stage power calculation and a 17-stage square-root
// pipeline into a four-entry queue and is written to the magnitude store
// while the first peak is tracked. After the last bin the back end reads
// the store one entry per cycle for the second peak, through the single
// store read port. During that pass the pipeline and queue keep taking
// bins until the queue is full and a bin waits at the root output (at
// most 23 held), then in_ready drops until the result is loaded.
// Depends on stpf_pkg, stpf_front, stpf_queue and stpf_back.
module spectrum_two_peak_finder #(
  parameter int BIN_COUNT = stpf_pkg::BIN_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [stpf_pkg::GUARD_W-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [stpf_pkg::REAL_W-1:0] real_part,
  input  logic signed [stpf_pkg::REAL_W-1:0] imag_part,
  input  logic                               last_bin,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [stpf_pkg::INDEX_W-1:0]       first_index,
  output logic [stpf_pkg::LEVEL_W-1:0]       first_level,
  output logic [stpf_pkg::INDEX_W-1:0]       second_index,
  output logic [stpf_pkg::LEVEL_W-1:0]       second_level
);
  import stpf_pkg::*;

  logic [GUARD_W-1:0] guard_bins;
  logic               push_valid;
  logic               push_ready;
  bin_item_t          push_item;
  logic               pop_valid;
  logic               pop_ready;
  bin_item_t          pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_bins <= GUARD_RESET;
    end else if (cfg_we) begin
      guard_bins <= cfg_data;
    end
  end

  stpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .real_part  (real_part),
    .imag_part  (imag_part),
    .last_bin   (last_bin),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  stpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  stpf_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .guard_bins   (guard_bins),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_index  (first_index),
    .first_level  (first_level),
    .second_index (second_index),
    .second_level (second_level)
  );

endmodule

[design/stpf_checker.sv]
// stpf_checker: port-level assertions on the result channel of the
// spectrum two-peak finder, bound to the top level. Depends on stpf_pkg.
module stpf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [stpf_pkg::INDEX_W-1:0] first_index,
  input logic [stpf_pkg::LEVEL_W-1:0] first_level,
  input logic [stpf_pkg::INDEX_W-1:0] second_index,
  input logic [stpf_pkg::LEVEL_W-1:0] second_level
);
  import stpf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_index) &&
      $stable(first_level) && $stable(second_index) && $stable(second_level))
    else $error("result changed before transfer");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> first_level >= second_level)
    else $error("second peak above first peak");

  a_all_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (first_level == '0) |->
      (first_index == '0) && (second_index == '0) && (second_level == '0))
    else $error("nonzero fields on empty spectrum");

  a_second_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && (second_level != '0) |-> (second_index != '0) && (first_index != '0))
    else $error("peak reported at bin zero");

endmodule

bind spectrum_two_peak_finder stpf_checker u_stpf_checker (.*);

[test/spectrum_two_peak_finder_checker.sv]
// Checker for spectrum_two_peak_finder: watches the config port and both
// channels, predicts the two peaks of every spectrum and compares results.
// Depends on stpf_pkg.
module spectrum_two_peak_finder_checker #(
  parameter int BINS = stpf_pkg::BIN_COUNT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [stpf_pkg::GUARD_W-1:0]       cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [stpf_pkg::REAL_W-1:0] real_part,
  input  logic signed [stpf_pkg::REAL_W-1:0] imag_part,
  input  logic                               last_bin,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [stpf_pkg::INDEX_W-1:0]       first_index,
  input  logic [stpf_pkg::LEVEL_W-1:0]       first_level,
  input  logic [stpf_pkg::INDEX_W-1:0]       second_index,
  input  logic [stpf_pkg::LEVEL_W-1:0]       second_level,
  output int                                 fail_count,
  output int                                 pending_results
);
  import stpf_pkg::*;

  typedef struct {
    logic [INDEX_W-1:0] first_index;
    logic [LEVEL_W-1:0] first_level;
    logic [INDEX_W-1:0] second_index;
    logic [LEVEL_W-1:0] second_level;
  } peak_pair_t;

  logic [LEVEL_W-1:0] level_store [BINS];
  int unsigned        fill;
  logic [GUARD_W-1:0] guard;
  peak_pair_t         expected_peaks [$];
  int                 errors;

  // bitwise search for the largest r with r*r <= v
  function automatic logic [LEVEL_W-1:0] floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = LEVEL_W; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return LEVEL_W'(r);
  endfunction

  task automatic find_peak(input int unsigned count, output int idx,
                           output logic [LEVEL_W-1:0] lvl);
    lvl = '0;
    idx = 0;
    for (int unsigned i = 1; i < count; i++) begin
      if (level_store[i] > lvl) begin
        lvl = level_store[i];
        idx = i;
      end
    end
  endtask

  task automatic take_bin(input logic signed [REAL_W-1:0] re,
                          input logic signed [REAL_W-1:0] im, input logic last);
    longint unsigned      pw;
    int                   idx;
    int                   lo;
    int                   hi;
    logic [LEVEL_W-1:0]   lvl;
    peak_pair_t           pk;
    pw = longint'(re) * longint'(re) + longint'(im) * longint'(im);
    // bins past the store depth are dropped
    if (fill < BINS) begin
      level_store[fill] = (fill == 0) ? floor_root(pw) : floor_root(pw << 2);
      fill++;
    end
    if (last) begin
      find_peak(fill, idx, lvl);
      pk.first_index = INDEX_W'(idx);
      pk.first_level = lvl;
      lo = idx - int'(guard);
      hi = idx + int'(guard) - 1;
      if (lo < 0) lo = 0;
      if (hi > int'(fill) - 1) hi = int'(fill) - 1;
      for (int k = lo; k <= hi; k++) level_store[k] = '0;
      find_peak(fill, idx, lvl);
      pk.second_index = INDEX_W'(idx);
      pk.second_level = lvl;
      fill = 0;
      expected_peaks.push_back(pk);
    end
  endtask

  task automatic report_mismatch(input string note);
    errors++;
    $display("%0t: peak mismatch: %s", $time, note);
  endtask

  task automatic check_result();
    peak_pair_t want;
    if (expected_peaks.size() == 0) begin
      report_mismatch($sformatf("unexpected transfer %0d/%0d %0d/%0d", first_index,
                                first_level, second_index, second_level));
      return;
    end
    want = expected_peaks.pop_front();
    if (first_index !== want.first_index)
      report_mismatch($sformatf("first_index got %0d want %0d", first_index,
                                want.first_index));
    if (first_level !== want.first_level)
      report_mismatch($sformatf("first_level got %0d want %0d", first_level,
                                want.first_level));
    if (second_index !== want.second_index)
      report_mismatch($sformatf("second_index got %0d want %0d", second_index,
                                want.second_index));
    if (second_level !== want.second_level)
      report_mismatch($sformatf("second_level got %0d want %0d", second_level,
                                want.second_level));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      guard = GUARD_RESET;
      expected_peaks.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_we) guard = cfg_data;
      if (in_valid && in_ready) take_bin(real_part, imag_part, last_bin);
    end
    fail_count <= errors;
    pending_results <= expected_peaks.size();
  end

endmodule

[test/spectrum_two_peak_finder_test.sv]
// Top of the spectrum_two_peak_finder testbench: clock, reset, spectra
// stimulus, result back-pressure and the verdict. Depends on stpf_pkg,
// spectrum_two_peak_finder and spectrum_two_peak_finder_checker.
module spectrum_two_peak_finder_test;
  import stpf_pkg::*;

  localparam int LIMIT       = 1_000_000;
  localparam int SETTLE      = 40;
  localparam int DRAIN       = 64;
  localparam int LONG_HOLD   = 600;
  localparam int ITEMS       = 1250;
  localparam int MIN_SPECTRA = 40;

  typedef enum {FULL_RANDOM, NOISE_PEAKS, ALL_ZERO, EXTREMES} spectrum_shape_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [GUARD_W-1:0]         cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [REAL_W-1:0]   real_part;
  logic signed [REAL_W-1:0]   imag_part;
  logic                       last_bin;
  logic                       out_valid;
  logic                       out_ready;
  logic [INDEX_W-1:0]         first_index;
  logic [LEVEL_W-1:0]         first_level;
  logic [INDEX_W-1:0]         second_index;
  logic [LEVEL_W-1:0]         second_level;
  int                         fail_count;
  int                         pending_results;

  int cycles = 0;
  int bins_sent = 0;
  int spectra_sent = 0;
  bit in_idles = 1;
  bit out_idles = 1;
  bit hold_results = 0;

  spectrum_two_peak_finder dut (.*);

  spectrum_two_peak_finder_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ends at the rising edge of the transfer; valid stays up
  task automatic send_bin(input logic signed [REAL_W-1:0] re,
                          input logic signed [REAL_W-1:0] im, input logic last);
    int gap;
    gap = in_idles ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    real_part <= re;
    imag_part <= im;
    last_bin <= last;
    do @(posedge clk); while (!in_ready);
    bins_sent++;
  endtask

  task automatic write_guard(input logic [GUARD_W-1:0] g);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (SETTLE) @(negedge clk);
    cfg_data <= g;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [REAL_W-1:0] pick_value(input spectrum_shape_t shape);
    case (shape)
      FULL_RANDOM: return REAL_W'($urandom);
      NOISE_PEAKS: return REAL_W'($urandom_range(0, 40) - 20);
      EXTREMES: begin
        case ($urandom_range(0, 4))
          0: return REAL_W'(-32768);
          1: return REAL_W'(32767);
          2: return REAL_W'(-1);
          3: return REAL_W'(1);
          default: return '0;
        endcase
      end
      default: return '0;
    endcase
  endfunction

  task automatic send_spectrum(input int len, input spectrum_shape_t shape);
    int                       p1;
    int                       p2;
    bit                       tie;
    logic signed [REAL_W-1:0] pk_re;
    logic signed [REAL_W-1:0] pk_im;
    logic signed [REAL_W-1:0] re;
    logic signed [REAL_W-1:0] im;
    p1 = $urandom_range(0, len - 1);
    p2 = $urandom_range(0, len - 1);
    tie = ($urandom_range(0, 2) == 0);
    pk_re = REAL_W'($urandom);
    pk_im = REAL_W'($urandom);
    for (int i = 0; i < len; i++) begin
      if (shape == NOISE_PEAKS && i == p1) begin
        re = pk_re;
        im = pk_im;
      end else if (shape == NOISE_PEAKS && i == p2) begin
        // rotated copy of the main peak gives an equal magnitude
        re = tie ? -pk_im : REAL_W'($urandom_range(0, 8000) - 4000);
        im = tie ? pk_re : REAL_W'($urandom_range(0, 8000) - 4000);
      end else begin
        re = pick_value(shape);
        im = pick_value(shape);
      end
      send_bin(re, im, i == len - 1);
    end
    spectra_sent++;
  endtask

  // result side
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_results) begin
        gap = LONG_HOLD;
        hold_results = 0;
      end else begin
        gap = out_idles ? $urandom_range(0, 9) : 0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int              phase;
    int              pick;
    int              len;
    spectrum_shape_t shape;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    real_part = '0;
    imag_part = '0;
    last_bin = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset guard: single bin, all zero, field extremes, magnitude tie
    send_bin(-32768, -32768, 1'b1);
    send_bin(0, 0, 1'b0);
    send_bin(0, 0, 1'b0);
    send_bin(0, 0, 1'b1);
    send_bin(32767, 32767, 1'b0);
    send_bin(-32768, -32768, 1'b0);
    send_bin(-32768, 0, 1'b0);
    send_bin(0, 32767, 1'b0);
    send_bin(1, 0, 1'b0);
    send_bin(-1, -1, 1'b1);
    send_bin(0, 0, 1'b0);
    send_bin(3, 4, 1'b0);
    send_bin(4, -3, 1'b0);
    send_bin(-3, -4, 1'b1);
    // zero guard: second peak may land on the first
    write_guard(0);
    send_bin(0, 0, 1'b0);
    send_bin(100, 0, 1'b0);
    send_bin(0, -100, 1'b1);
    write_guard(1);
    send_bin(0, 0, 1'b0);
    send_bin(5, 0, 1'b0);
    send_bin(9, 0, 1'b0);
    send_bin(9, 0, 1'b0);
    send_bin(2, 0, 1'b1);

    phase = 0;
    while (bins_sent < ITEMS || spectra_sent < MIN_SPECTRA) begin
      case (phase)
        0: write_guard(63);
        1: write_guard(0);
        2: write_guard(1);
        default: write_guard(GUARD_W'($urandom_range(0, 63)));
      endcase
      if (phase == 0) send_spectrum(520, NOISE_PEAKS);
      if (phase == 3) begin
        // results held back while short spectra keep coming
        in_idles = 0;
        hold_results = 1;
        repeat (16) send_spectrum($urandom_range(2, 5), NOISE_PEAKS);
      end
      repeat (6) begin
        in_idles = ($urandom_range(0, 3) != 0);
        out_idles = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 9);
        len = (pick == 0) ? $urandom_range(1, 4) : $urandom_range(5, 32);
        pick = $urandom_range(0, 19);
        shape = (pick < 6) ? FULL_RANDOM : (pick < 16) ? NOISE_PEAKS :
                (pick < 17) ? ALL_ZERO : EXTREMES;
        send_spectrum(len, shape);
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results == 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
